// File: rtl/core/cbq_pkg.sv
// Shared types, constants and saturation helpers of the cascaded biquad filter.
// Used by the controller, the datapath and the top level; depends on nothing.
package cbq_pkg;

  localparam int MAX_STAGES_DEF = 8;
  localparam int TRACKS_DEF     = 8;

  localparam logic signed [31:0] ONE_Q28    = 32'sd268435456;
  localparam logic signed [32:0] NEAR_LEVEL = 33'sd4254;

  // Configuration register indexes.
  localparam logic [2:0] REG_FILTER_TYPE = 3'd0;
  localparam logic [2:0] REG_BASE_GAIN   = 3'd1;
  localparam logic [2:0] REG_HI_BAND     = 3'd2;
  localparam logic [2:0] REG_LO_BAND     = 3'd3;
  localparam logic [2:0] REG_STAGE_COUNT = 3'd4;

  localparam logic [1:0] FT_BUTTERWORTH = 2'd0;
  localparam logic [1:0] FT_BESSEL      = 2'd1;

  localparam logic OP_FILTER = 1'b0;
  localparam logic OP_COEF   = 1'b1;

  localparam logic [1:0] TERM_C0 = 2'd0;
  localparam logic [1:0] TERM_C1 = 2'd1;
  localparam logic [1:0] TERM_C2 = 2'd2;
  localparam logic [1:0] TERM_C3 = 2'd3;

  typedef enum logic [4:0] {
    ST_CLEAR, ST_IDLE, ST_GAIN, ST_KSAT, ST_CHECK, ST_UMUL, ST_ULOAD,
    ST_HRD0, ST_HRD1, ST_HCAP1, ST_CRD, ST_MHI, ST_MLO, ST_PADD, ST_ACC,
    ST_REC, ST_BSAT, ST_HWR0, ST_HWR1, ST_FIN
  } state_t;

  typedef enum logic [1:0] {MUL_GAIN, MUL_IN, MUL_HI, MUL_LO} mul_op_t;
  typedef enum logic [1:0] {RES_PASS, RES_ZERO, RES_FILT} res_t;

  typedef struct packed {
    logic       latch;
    logic       coef_we;
    logic       clr_step;
    mul_op_t    mul_op;
    logic       k_load;
    logic       u_load;
    logic       pacc_hi;
    logic       pacc_add;
    logic       acc_add;
    logic       rec_sat;
    logic       acc_sat;
    logic       hist_rd_sel;
    logic       h0_cap;
    logic       h1_cap;
    logic       hist_wr;
    logic       hist_wr_sel;
    logic [1:0] term;
    logic       stage_clr;
    logic       stage_inc;
    logic       out_load;
    res_t       res_sel;
  } dp_cmd_t;

  typedef struct packed {
    logic clr_done;
    logic is_pass;
    logic is_zero;
    logic last_stage;
    logic is_bw;
    logic out_free;
  } dp_sts_t;

  function automatic logic signed [39:0] sat40(input logic signed [47:0] v);
    logic signed [39:0] r;
    if (v > 48'sh007F_FFFF_FFFF) r = 40'sh7F_FFFF_FFFF;
    else if (v < -48'sh0080_0000_0000) r = -40'sh80_0000_0000;
    else r = v[39:0];
    return r;
  endfunction

  function automatic logic signed [23:0] sat24(input logic signed [31:0] v);
    logic signed [23:0] r;
    if (v > 32'sd8388607) r = 24'sh7FFFFF;
    else if (v < -32'sd8388608) r = -24'sh800000;
    else r = v[23:0];
    return r;
  endfunction

endpackage

// File: rtl/core/cascaded_biquad_filter_core.sv
// Top level of the multi-track cascaded biquad IIR filter.
// Uses cbq_pkg; instantiates cbq_ctrl and cbq_dp.
//
// After reset the block clears all TRACKS*MAX_STAGES*2 history RAM entries
// (128 at the defaults), one entry a cycle, and takes no item then.
// A coefficient item is written as it is accepted. A sample item goes through
// the gain, then per stage four coefficient terms for Butterworth or two for
// the other types, then waits for a free output register; unity gain samples,
// and zero gain samples with a stage count below 2, skip the stage loop. The
// single shared multiplier sets the pace: each 40 by 32 bit history product
// is built from two passes through it. One sample is in work at a time; the
// next item is taken while a finished result waits in the output register.
module cascaded_biquad_filter_core
  import cbq_pkg::*;
#(
  parameter int MAX_STAGES = MAX_STAGES_DEF,
  parameter int TRACKS     = TRACKS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [31:0] cfg_wdata,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [63:0] s_tdata,   // track[2:0], sample_in[26:3], coef_index[31:27],
                                 // coef_value[63:32]
  input  logic        s_tlast,
  input  logic        s_tuser,   // op
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [31:0] m_tdata,   // track_out[2:0], sample_out[26:3], zero[31:27]
  output logic        m_tlast
);

  dp_cmd_t            cmd;
  dp_sts_t            sts;
  logic [2:0]         out_track;
  logic signed [23:0] out_sample;

  cbq_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tuser  (s_tuser),
    .s_tready (s_tready),
    .sts      (sts),
    .cmd      (cmd)
  );

  cbq_dp #(.MAX_STAGES(MAX_STAGES), .TRACKS(TRACKS)) u_dp (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata),
    .in_track   (s_tdata[2:0]),
    .in_sample  (s_tdata[26:3]),
    .in_last    (s_tlast),
    .in_cidx    (s_tdata[31:27]),
    .in_cval    (s_tdata[63:32]),
    .cmd        (cmd),
    .sts        (sts),
    .out_ready  (m_tready),
    .out_valid  (m_tvalid),
    .out_track  (out_track),
    .out_sample (out_sample),
    .out_last   (m_tlast)
  );

  assign m_tdata = {5'd0, out_sample, out_track};

  // A result is never loaded over one that has not been taken.
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    cmd.out_load |-> sts.out_free)
    else $error("result loaded while output register is occupied");

  // Accepting a sample starts work, so the input side closes next cycle.
  a_sample_busy: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready && s_tuser == OP_FILTER |=> !s_tready)
    else $error("input still ready after a sample was accepted");

  // The accumulator registers take at most one update per cycle.
  a_acc_single: assert property (@(posedge clk) disable iff (rst)
    $onehot0({cmd.u_load, cmd.acc_add, cmd.rec_sat, cmd.acc_sat,
              cmd.pacc_hi, cmd.pacc_add}))
    else $error("conflicting accumulator commands");

endmodule

// File: rtl/core/cbq_ram.sv
// Generic simple dual-port RAM: one write port, one read port, registered read.
// Holds the history and coefficient stores; no dependencies.
module cbq_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 32
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                       wdata,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: rtl/core/cbq_ctrl.sv
// Sequencer of the cascaded biquad filter: clearing pass, gain, stage loop.
// Uses cbq_pkg; drives the datapath only through dp_cmd_t and reads dp_sts_t.
module cbq_ctrl
  import cbq_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    s_tvalid,
  input  logic    s_tuser,
  output logic    s_tready,
  input  dp_sts_t sts,
  output dp_cmd_t cmd
);

  state_t     state, state_next;
  logic [1:0] term, term_next;
  res_t       res, res_next;
  logic       accept;

  assign accept = s_tvalid && s_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
      term  <= TERM_C0;
      res   <= RES_FILT;
    end else begin
      state <= state_next;
      term  <= term_next;
      res   <= res_next;
    end
  end

  always_comb begin
    state_next = state;
    term_next  = term;
    res_next   = res;
    unique case (state)
      ST_CLEAR: if (sts.clr_done) state_next = ST_IDLE;
      ST_IDLE:  if (accept && s_tuser == OP_FILTER) state_next = ST_GAIN;
      ST_GAIN:  state_next = ST_KSAT;
      ST_KSAT:  state_next = ST_CHECK;
      ST_CHECK: begin
        if (sts.is_pass) begin
          res_next   = RES_PASS;
          state_next = ST_FIN;
        end else if (sts.is_zero) begin
          res_next   = RES_ZERO;
          state_next = ST_FIN;
        end else begin
          res_next   = RES_FILT;
          state_next = ST_UMUL;
        end
      end
      ST_UMUL:  state_next = ST_ULOAD;
      ST_ULOAD: state_next = ST_HRD0;
      ST_HRD0: begin
        term_next  = TERM_C0;
        state_next = ST_HRD1;
      end
      ST_HRD1:  state_next = ST_HCAP1;
      ST_HCAP1: state_next = ST_CRD;
      ST_CRD:   state_next = ST_MHI;
      ST_MHI:   state_next = ST_MLO;
      ST_MLO:   state_next = ST_PADD;
      ST_PADD:  state_next = ST_ACC;
      ST_ACC: begin
        if (term == TERM_C1) state_next = ST_REC;
        else if (term == TERM_C3) state_next = ST_BSAT;
        else begin
          term_next  = term + 2'd1;
          state_next = ST_CRD;
        end
      end
      ST_REC: begin
        if (sts.is_bw) begin
          term_next  = TERM_C2;
          state_next = ST_CRD;
        end else begin
          state_next = ST_HWR0;
        end
      end
      ST_BSAT: state_next = ST_HWR0;
      ST_HWR0: state_next = ST_HWR1;
      ST_HWR1: state_next = sts.last_stage ? ST_FIN : ST_HRD0;
      ST_FIN:  if (sts.out_free) state_next = ST_IDLE;
      default: state_next = ST_CLEAR;
    endcase
  end

  always_comb begin
    cmd         = '0;
    cmd.mul_op  = MUL_HI;
    cmd.term    = term;
    cmd.res_sel = res;
    s_tready    = 1'b0;
    unique case (state)
      ST_CLEAR: cmd.clr_step = 1'b1;
      ST_IDLE: begin
        s_tready    = 1'b1;
        cmd.latch   = accept;
        cmd.coef_we = accept && s_tuser == OP_COEF;
      end
      ST_GAIN:  cmd.mul_op = MUL_GAIN;
      ST_KSAT:  cmd.k_load = 1'b1;
      ST_CHECK: ;
      ST_UMUL:  cmd.mul_op = MUL_IN;
      ST_ULOAD: begin
        cmd.u_load    = 1'b1;
        cmd.stage_clr = 1'b1;
      end
      ST_HRD0: cmd.hist_rd_sel = 1'b0;
      ST_HRD1: begin
        cmd.hist_rd_sel = 1'b1;
        cmd.h0_cap      = 1'b1;
      end
      ST_HCAP1: cmd.h1_cap = 1'b1;
      ST_CRD:   ;
      ST_MHI:   cmd.mul_op = MUL_HI;
      ST_MLO: begin
        cmd.mul_op  = MUL_LO;
        cmd.pacc_hi = 1'b1;
      end
      ST_PADD: cmd.pacc_add = 1'b1;
      ST_ACC:  cmd.acc_add  = 1'b1;
      ST_REC:  cmd.rec_sat  = 1'b1;
      ST_BSAT: cmd.acc_sat  = 1'b1;
      ST_HWR0: begin
        cmd.hist_wr     = 1'b1;
        cmd.hist_wr_sel = 1'b1;
      end
      ST_HWR1: begin
        cmd.hist_wr     = 1'b1;
        cmd.hist_wr_sel = 1'b0;
        cmd.stage_inc   = !sts.last_stage;
      end
      ST_FIN: cmd.out_load = sts.out_free;
      default: ;
    endcase
  end

endmodule

// File: rtl/core/cbq_dp.sv
// Datapath of the cascaded biquad filter: config registers, shared multiplier,
// accumulators, history and coefficient RAMs, output register. Uses cbq_pkg, cbq_ram.
module cbq_dp
  import cbq_pkg::*;
#(
  parameter int MAX_STAGES = MAX_STAGES_DEF,
  parameter int TRACKS     = TRACKS_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_we,
  input  logic [2:0]         cfg_index,
  input  logic [31:0]        cfg_wdata,
  input  logic [2:0]         in_track,
  input  logic signed [23:0] in_sample,
  input  logic               in_last,
  input  logic [4:0]         in_cidx,
  input  logic signed [31:0] in_cval,
  input  dp_cmd_t            cmd,
  output dp_sts_t            sts,
  input  logic               out_ready,
  output logic               out_valid,
  output logic [2:0]         out_track,
  output logic signed [23:0] out_sample,
  output logic               out_last
);

  localparam int HIST_DEPTH = TRACKS * MAX_STAGES * 2;
  localparam int HA_W       = $clog2(HIST_DEPTH);
  localparam int COEF_DEPTH = MAX_STAGES * 4;
  localparam int CA_W       = $clog2(COEF_DEPTH);
  localparam int STG_W      = MAX_STAGES > 1 ? $clog2(MAX_STAGES) : 1;
  localparam logic [HA_W-1:0] TRK_STRIDE = HA_W'(MAX_STAGES * 2);

  // Configuration registers.
  logic [1:0]         filter_type;
  logic signed [31:0] base_gain, hi_band_gain, lo_band_gain;
  logic [3:0]         stage_count;

  always_ff @(posedge clk) begin
    if (rst) begin
      filter_type  <= FT_BUTTERWORTH;
      base_gain    <= ONE_Q28;
      hi_band_gain <= ONE_Q28;
      lo_band_gain <= '0;
      stage_count  <= 4'd1;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_FILTER_TYPE: filter_type  <= cfg_wdata[1:0];
        REG_BASE_GAIN:   base_gain    <= cfg_wdata;
        REG_HI_BAND:     hi_band_gain <= cfg_wdata;
        REG_LO_BAND:     lo_band_gain <= cfg_wdata;
        REG_STAGE_COUNT: stage_count  <= cfg_wdata[3:0];
        default: ;
      endcase
    end
  end

  // Latched item fields.
  logic [2:0]         track;
  logic signed [23:0] x;
  logic               last;

  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      track <= in_track;
      x     <= in_sample;
      last  <= in_last;
    end
  end

  // History track: raw track reduced modulo the track count.
  logic [5:0] trk;
  always_comb begin
    trk = 6'(track);
    for (int i = 0; i < 8; i++) begin
      if (trk >= 6'(TRACKS)) trk = trk - 6'(TRACKS);
    end
  end

  // Stage counter and stage limit.
  logic [STG_W-1:0] stage, stages_m1;
  always_ff @(posedge clk) begin
    if (cmd.stage_clr) stage <= '0;
    else if (cmd.stage_inc) stage <= stage + 1'b1;
  end

  always_comb begin
    if (stage_count == 4'd0) stages_m1 = '0;
    else if ({1'b0, stage_count} > 5'(MAX_STAGES)) stages_m1 = STG_W'(MAX_STAGES - 1);
    else stages_m1 = STG_W'(stage_count - 4'd1);
  end

  // Clearing pass counter.
  logic [HA_W-1:0] clr_cnt;
  always_ff @(posedge clk) begin
    if (rst) clr_cnt <= '0;
    else if (cmd.clr_step) clr_cnt <= clr_cnt + 1'b1;
  end

  // History RAM.
  logic [HA_W-1:0]    hist_base, hist_raddr, hist_waddr;
  logic [39:0]        hist_wdata, hist_rdata;
  logic signed [39:0] h0, h1, rec;

  assign hist_base  = HA_W'(trk) * TRK_STRIDE + (HA_W'(stage) << 1);
  assign hist_raddr = hist_base + HA_W'(cmd.hist_rd_sel);
  assign hist_waddr = cmd.clr_step ? clr_cnt : hist_base + HA_W'(cmd.hist_wr_sel);
  assign hist_wdata = cmd.clr_step ? 40'd0 : (cmd.hist_wr_sel ? h0 : rec);

  cbq_ram #(.WIDTH(40), .DEPTH(HIST_DEPTH)) u_hist (
    .clk   (clk),
    .we    (cmd.clr_step || cmd.hist_wr),
    .waddr (hist_waddr),
    .wdata (hist_wdata),
    .raddr (hist_raddr),
    .rdata (hist_rdata)
  );

  always_ff @(posedge clk) begin
    if (cmd.h0_cap) h0 <= hist_rdata;
    if (cmd.h1_cap) h1 <= hist_rdata;
  end

  // Coefficient RAM.
  logic               coef_ok;
  logic [CA_W-1:0]    coef_raddr;
  logic signed [31:0] coef;

  assign coef_ok    = {2'b00, in_cidx} < 7'(COEF_DEPTH);
  assign coef_raddr = (CA_W'(stage) << 2) | CA_W'(cmd.term);

  cbq_ram #(.WIDTH(32), .DEPTH(COEF_DEPTH)) u_coef (
    .clk   (clk),
    .we    (cmd.coef_we && coef_ok),
    .waddr (CA_W'(in_cidx)),
    .wdata (in_cval),
    .raddr (coef_raddr),
    .rdata (coef)
  );

  // Shared multiplier. A 40-bit history value is split into a signed upper
  // part and an unsigned lower 20 bits so each product fits one multiply.
  logic               is_bessel;
  logic signed [39:0] hsel;
  logic signed [32:0] mul_a;
  logic signed [31:0] mul_b;
  logic signed [64:0] mr;
  logic signed [31:0] k;

  assign is_bessel = filter_type == FT_BESSEL;
  assign hsel      = cmd.term[0] ? h1 : h0;

  always_comb begin
    case (cmd.mul_op)
      MUL_GAIN: begin
        mul_a = is_bessel ? 33'(hi_band_gain) - 33'(lo_band_gain) : 33'(hi_band_gain);
        mul_b = base_gain;
      end
      MUL_IN: begin
        mul_a = 33'(x);
        mul_b = k;
      end
      MUL_HI: begin
        mul_a = 33'($signed(hsel[39:20]));
        mul_b = coef;
      end
      default: begin
        mul_a = $signed({13'd0, hsel[19:0]});
        mul_b = coef;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    mr <= mul_a * mul_b;
  end

  // Gain saturation and the unity and zero gain checks.
  logic signed [36:0] kw;
  logic signed [32:0] kd, ke;
  assign kw = $signed(mr[64:28]);
  assign ke = 33'(k);
  assign kd = ke - 33'(ONE_Q28);

  always_ff @(posedge clk) begin
    if (cmd.k_load) begin
      if (kw > 37'sd2147483647) k <= 32'sh7FFF_FFFF;
      else if (kw < -37'sd2147483648) k <= -32'sh8000_0000;
      else k <= kw[31:0];
    end
  end

  // Product and stage accumulators.
  logic signed [71:0] pacc;
  logic signed [47:0] acc;

  always_ff @(posedge clk) begin
    if (cmd.pacc_hi) pacc <= 72'(mr) <<< 20;
    else if (cmd.pacc_add) pacc <= pacc + 72'(mr);
  end

  always_ff @(posedge clk) begin
    if (cmd.u_load) acc <= 48'($signed(mr[64:20]));
    else if (cmd.acc_add) acc <= acc + 48'($signed(pacc[71:28]));
    else if (cmd.rec_sat || cmd.acc_sat) acc <= 48'(sat40(acc));
    if (cmd.rec_sat) rec <= sat40(acc);
  end

  // Output register.
  logic signed [23:0] y;
  always_comb begin
    case (cmd.res_sel)
      RES_PASS: y = x;
      RES_ZERO: y = '0;
      default:  y = sat24($signed(acc[39:8]));
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) out_valid <= 1'b0;
    else if (cmd.out_load) out_valid <= 1'b1;
    else if (out_ready) out_valid <= 1'b0;
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_track  <= track;
      out_sample <= y;
      out_last   <= last;
    end
  end

  always_comb begin
    sts.clr_done   = clr_cnt == HA_W'(HIST_DEPTH - 1);
    sts.is_pass    = kd > -NEAR_LEVEL && kd < NEAR_LEVEL;
    sts.is_zero    = ke > -NEAR_LEVEL && ke < NEAR_LEVEL && stage_count < 4'd2;
    sts.last_stage = stage == stages_m1;
    sts.is_bw      = filter_type == FT_BUTTERWORTH;
    sts.out_free   = !out_valid || out_ready;
  end

endmodule
